// File: sv/brs_pkg.sv
// shared types, constants and the microcode table of the binomial reduce schedule
// no dependencies; every other file imports this package
package brs_pkg;

  localparam int MAX_RANKS_DEF = 1024;
  localparam int GROUP_W = 11;
  localparam int RANK_W = 10;
  localparam int COUNT_W = 31;
  localparam int CALC_W = 12;
  localparam int OUT_LIMIT = 32;
  localparam int NUM_W = 6;

  localparam logic [0:0] REG_GROUP_SIZE = 1'b0;
  localparam logic [0:0] REG_MY_RANK = 1'b1;

  localparam logic [2:0] ACT_COPY_IN = 3'd0;
  localparam logic [2:0] ACT_RECV_TMP = 3'd1;
  localparam logic [2:0] ACT_RED_TMP_LOCAL = 3'd2;
  localparam logic [2:0] ACT_RED_LOCAL_TMP = 3'd3;
  localparam logic [2:0] ACT_COPY_BACK = 3'd4;
  localparam logic [2:0] ACT_SEND = 3'd5;
  localparam logic [2:0] ACT_RECV_LOCAL = 3'd6;
  localparam logic [2:0] ACT_ERROR = 3'd7;

  localparam int PC_W = 5;
  localparam logic [PC_W-1:0] PC_IDLE = 5'd0;
  localparam logic [PC_W-1:0] PC_ZERO = 5'd1;
  localparam logic [PC_W-1:0] PC_BAD = 5'd2;
  localparam logic [PC_W-1:0] PC_COPY = 5'd3;
  localparam logic [PC_W-1:0] PC_LOOP = 5'd4;
  localparam logic [PC_W-1:0] PC_TEST = 5'd5;
  localparam logic [PC_W-1:0] PC_RECV = 5'd6;
  localparam logic [PC_W-1:0] PC_RED_COMM = 5'd7;
  localparam logic [PC_W-1:0] PC_RED_NCOMM = 5'd8;
  localparam logic [PC_W-1:0] PC_BACK = 5'd9;
  localparam logic [PC_W-1:0] PC_ADV = 5'd10;
  localparam logic [PC_W-1:0] PC_SEND = 5'd11;
  localparam logic [PC_W-1:0] PC_TAIL = 5'd12;
  localparam logic [PC_W-1:0] PC_HOP = 5'd13;
  localparam logic [PC_W-1:0] PC_HOP_RECV = 5'd14;
  localparam logic [PC_W-1:0] PC_ERR = 5'd15;
  localparam logic [PC_W-1:0] PC_END = 5'd16;

  localparam int COND_W = 4;
  localparam logic [COND_W-1:0] C_NEVER = 4'd0;
  localparam logic [COND_W-1:0] C_ALWAYS = 4'd1;
  localparam logic [COND_W-1:0] C_ZERO = 4'd2;
  localparam logic [COND_W-1:0] C_BAD = 4'd3;
  localparam logic [COND_W-1:0] C_ROOT_INPLACE = 4'd4;
  localparam logic [COND_W-1:0] C_MASK_DONE = 4'd5;
  localparam logic [COND_W-1:0] C_REL_BIT = 4'd6;
  localparam logic [COND_W-1:0] C_NO_CHILD = 4'd7;
  localparam logic [COND_W-1:0] C_NONCOMM = 4'd8;
  localparam logic [COND_W-1:0] C_NOT_HOP = 4'd9;
  localparam logic [COND_W-1:0] C_RANK_NZ = 4'd10;

  localparam logic [1:0] PS_ZERO = 2'd0;
  localparam logic [1:0] PS_CHILD = 2'd1;
  localparam logic [1:0] PS_PARENT = 2'd2;
  localparam logic [1:0] PS_ROOT = 2'd3;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_LOAD_REL = 2'd1;
  localparam logic [1:0] OP_SHIFT = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  typedef struct packed {
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
    logic [PC_W-1:0]   next;
    logic              emit;
    logic [2:0]        act;
    logic [1:0]        peer_sel;
    logic [1:0]        op;
  } ctrl_t;

  typedef struct packed {
    logic zero;
    logic bad;
    logic root_inplace;
    logic mask_done;
    logic rel_bit;
    logic no_child;
    logic noncomm;
    logic not_hop;
    logic rank_nz;
  } flags_t;

  typedef struct packed {
    logic       start;
    logic       emit;
    logic       flush;
    logic [2:0] act;
  } emit_req_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '{cond: C_NEVER, target: PC_IDLE, next: PC_IDLE, emit: 1'b0,
          act: ACT_COPY_IN, peer_sel: PS_ZERO, op: OP_NONE};
    case (pc)
      PC_ZERO: begin
        w.cond = C_ZERO; w.target = PC_END; w.next = PC_BAD;
      end
      PC_BAD: begin
        w.cond = C_BAD; w.target = PC_ERR; w.next = PC_COPY; w.op = OP_LOAD_REL;
      end
      PC_COPY: begin
        w.cond = C_ROOT_INPLACE; w.target = PC_LOOP; w.next = PC_LOOP;
        w.emit = 1'b1; w.act = ACT_COPY_IN;
      end
      PC_LOOP: begin
        w.cond = C_MASK_DONE; w.target = PC_TAIL; w.next = PC_TEST;
      end
      PC_TEST: begin
        w.cond = C_REL_BIT; w.target = PC_SEND; w.next = PC_RECV;
      end
      PC_RECV: begin
        w.cond = C_NO_CHILD; w.target = PC_ADV; w.next = PC_RED_COMM;
        w.emit = 1'b1; w.act = ACT_RECV_TMP; w.peer_sel = PS_CHILD;
      end
      PC_RED_COMM: begin
        w.cond = C_NONCOMM; w.target = PC_RED_NCOMM; w.next = PC_ADV;
        w.emit = 1'b1; w.act = ACT_RED_TMP_LOCAL;
      end
      PC_RED_NCOMM: begin
        w.next = PC_BACK; w.emit = 1'b1; w.act = ACT_RED_LOCAL_TMP;
      end
      PC_BACK: begin
        w.next = PC_ADV; w.emit = 1'b1; w.act = ACT_COPY_BACK;
      end
      PC_ADV: begin
        w.cond = C_ALWAYS; w.target = PC_LOOP; w.next = PC_LOOP; w.op = OP_SHIFT;
      end
      PC_SEND: begin
        w.next = PC_TAIL; w.emit = 1'b1; w.act = ACT_SEND; w.peer_sel = PS_PARENT;
      end
      PC_TAIL: begin
        w.cond = C_NOT_HOP; w.target = PC_END; w.next = PC_HOP;
      end
      PC_HOP: begin
        w.cond = C_RANK_NZ; w.target = PC_HOP_RECV; w.next = PC_END;
        w.emit = 1'b1; w.act = ACT_SEND; w.peer_sel = PS_ROOT;
      end
      PC_HOP_RECV: begin
        w.next = PC_END; w.emit = 1'b1; w.act = ACT_RECV_LOCAL;
      end
      PC_ERR: begin
        w.next = PC_END; w.emit = 1'b1; w.act = ACT_ERROR;
      end
      PC_END: begin
        w.next = PC_IDLE; w.op = OP_FLUSH;
      end
      default: begin
        w.next = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// File: sv/binomial_reduce_schedule.sv
// binomial-tree reduce schedule: top level with configuration registers
// depends on brs_pkg, brs_seq, brs_datapath, brs_out
//
// usage
//   write group_size (index 0) and my_rank (index 1) on the cfg port while idle
//   each input item is one reduce request; the block answers with this node's
//   action list on the output channel, one action per item, last set on the final one
//   a zero element count gives no actions; a root or own rank outside the group
//   gives a single error action
// timing
//   in_ready is high only while the sequencer is idle; one request at a time
//   the control table runs three setup steps, then three to seven steps per mask
//   level (check, test, receive, reduce, copy back, shift), then up to four tail steps
//   the sequencer takes one step per cycle while the output stage is not busy; each
//   action waits in the pending register until the next one or the end of the list, then
//   moves to the output register; a full list for 1024 ranks holds 32 actions
// reset and stall
//   rst clears the sequencer and the output stage; group_size returns to 1, my_rank to 0
//   when the receiver stalls, the output register holds its action and the
//   sequencer waits at its next emitting step or at its end step
module binomial_reduce_schedule #(
  parameter int MAX_RANKS = brs_pkg::MAX_RANKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [brs_pkg::GROUP_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [brs_pkg::RANK_W-1:0]    root_rank,
  input  logic                          commutative,
  input  logic                          in_place,
  input  logic [brs_pkg::COUNT_W-1:0]   element_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [2:0]                    action,
  output logic [brs_pkg::RANK_W-1:0]    peer,
  output logic                          last
);
  import brs_pkg::*;

  logic [GROUP_W-1:0] group_size;
  logic [RANK_W-1:0]  my_rank;
  flags_t             flags;
  ctrl_t              ctrl;
  emit_req_t          req;
  logic               load;
  logic               step;
  logic               busy;
  logic [RANK_W-1:0]  peer_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GROUP_W'(1);
      my_rank <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GROUP_SIZE: group_size <= cfg_data;
        REG_MY_RANK:    my_rank <= cfg_data[RANK_W-1:0];
        default:        group_size <= group_size;
      endcase
    end
  end

  brs_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .flags    (flags),
    .busy     (busy),
    .ctrl     (ctrl),
    .load     (load),
    .step     (step),
    .req      (req)
  );

  brs_datapath #(
    .MAX_RANKS (MAX_RANKS)
  ) u_datapath (
    .clk           (clk),
    .load          (load),
    .step          (step),
    .ctrl          (ctrl),
    .group_size    (group_size),
    .my_rank       (my_rank),
    .root_rank     (root_rank),
    .commutative   (commutative),
    .in_place      (in_place),
    .element_count (element_count),
    .flags         (flags),
    .peer_val      (peer_val)
  );

  brs_out u_out (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .peer_val  (peer_val),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .peer      (peer),
    .last      (last)
  );

endmodule

// File: sv/brs_seq.sv
// microcode sequencer: step counter, control table lookup and jump conditions
// depends on brs_pkg
module brs_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  brs_pkg::flags_t flags,
  input  logic            busy,
  output brs_pkg::ctrl_t  ctrl,
  output logic            load,
  output logic            step,
  output brs_pkg::emit_req_t req
);
  import brs_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            taken;
  logic            stall;

  assign ctrl = ucode(pc);
  assign in_ready = (pc == PC_IDLE);
  assign load = in_valid && in_ready;

  always_comb begin
    case (ctrl.cond)
      C_NEVER:        taken = 1'b0;
      C_ALWAYS:       taken = 1'b1;
      C_ZERO:         taken = flags.zero;
      C_BAD:          taken = flags.bad;
      C_ROOT_INPLACE: taken = flags.root_inplace;
      C_MASK_DONE:    taken = flags.mask_done;
      C_REL_BIT:      taken = flags.rel_bit;
      C_NO_CHILD:     taken = flags.no_child;
      C_NONCOMM:      taken = flags.noncomm;
      C_NOT_HOP:      taken = flags.not_hop;
      C_RANK_NZ:      taken = flags.rank_nz;
      default:        taken = 1'b0;
    endcase
  end

  assign stall = busy && (ctrl.emit || (ctrl.op == OP_FLUSH));
  assign step = (pc != PC_IDLE) && !stall;

  assign req.start = load;
  assign req.emit = step && ctrl.emit && !taken;
  assign req.flush = step && (ctrl.op == OP_FLUSH);
  assign req.act = ctrl.act;

  always_comb begin
    pc_next = pc;
    if (load) begin
      pc_next = PC_ZERO;
    end else if (step) begin
      pc_next = taken ? ctrl.target : ctrl.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// File: sv/brs_datapath.sv
// datapath: request registers, relative rank, mask walk, peer arithmetic and flags
// depends on brs_pkg
module brs_datapath #(
  parameter int MAX_RANKS = brs_pkg::MAX_RANKS_DEF
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  brs_pkg::ctrl_t                ctrl,
  input  logic [brs_pkg::GROUP_W-1:0]   group_size,
  input  logic [brs_pkg::RANK_W-1:0]    my_rank,
  input  logic [brs_pkg::RANK_W-1:0]    root_rank,
  input  logic                          commutative,
  input  logic                          in_place,
  input  logic [brs_pkg::COUNT_W-1:0]   element_count,
  output brs_pkg::flags_t               flags,
  output logic [brs_pkg::RANK_W-1:0]    peer_val
);
  import brs_pkg::*;

  localparam logic [GROUP_W-1:0] GMAX =
    (MAX_RANKS >= (1 << GROUP_W) - 1) ? GROUP_W'((1 << GROUP_W) - 1) : GROUP_W'(MAX_RANKS);

  logic [GROUP_W-1:0] g;
  logic [RANK_W-1:0]  rank;
  logic [RANK_W-1:0]  root;
  logic               comm;
  logic               inplace;
  logic               zero;
  logic [CALC_W-1:0]  rel;
  logic [CALC_W-1:0]  mask;

  logic [GROUP_W-1:0] g_sat;
  logic [RANK_W-1:0]  lroot;
  logic [CALC_W-1:0]  g_e;
  logic [CALC_W-1:0]  rank_e;
  logic [CALC_W-1:0]  lroot_e;
  logic [CALC_W-1:0]  rel_next;
  logic [CALC_W-1:0]  child;
  logic [CALC_W-1:0]  child_sum;
  logic [CALC_W-1:0]  parent_sum;
  logic [CALC_W-1:0]  child_peer;
  logic [CALC_W-1:0]  parent_peer;

  always_comb begin
    if (group_size == '0) begin
      g_sat = GROUP_W'(1);
    end else if (group_size > GMAX) begin
      g_sat = GMAX;
    end else begin
      g_sat = group_size;
    end
  end

  assign lroot = comm ? root : '0;
  assign g_e = CALC_W'(g);
  assign rank_e = CALC_W'(rank);
  assign lroot_e = CALC_W'(lroot);

  assign rel_next = (rank >= lroot) ? (rank_e - lroot_e) : (rank_e + g_e - lroot_e);

  assign child = rel | mask;
  assign child_sum = child + lroot_e;
  assign parent_sum = (rel & ~mask) + lroot_e;
  assign child_peer = (child_sum >= g_e) ? (child_sum - g_e) : child_sum;
  assign parent_peer = (parent_sum >= g_e) ? (parent_sum - g_e) : parent_sum;

  always_comb begin
    case (ctrl.peer_sel)
      PS_CHILD:  peer_val = child_peer[RANK_W-1:0];
      PS_PARENT: peer_val = parent_peer[RANK_W-1:0];
      PS_ROOT:   peer_val = root;
      default:   peer_val = '0;
    endcase
  end

  assign flags.zero = zero;
  assign flags.bad = (CALC_W'(root) >= g_e) || (rank_e >= g_e);
  assign flags.root_inplace = (rank == root) && inplace;
  assign flags.mask_done = (mask >= g_e);
  assign flags.rel_bit = ((rel & mask) != '0);
  assign flags.no_child = (child >= g_e);
  assign flags.noncomm = !comm;
  assign flags.not_hop = comm || (root == '0) || ((rank != '0) && (rank != root));
  assign flags.rank_nz = (rank != '0);

  always_ff @(posedge clk) begin
    if (load) begin
      g <= g_sat;
      rank <= my_rank;
      root <= root_rank;
      comm <= commutative;
      inplace <= in_place;
      zero <= (element_count == '0);
    end else if (step && (ctrl.op == OP_LOAD_REL)) begin
      rel <= rel_next;
      mask <= CALC_W'(1);
    end else if (step && (ctrl.op == OP_SHIFT)) begin
      mask <= {mask[CALC_W-2:0], 1'b0};
    end
  end

endmodule

// File: sv/brs_out.sv
// action staging: one pending action held back to learn its last flag, then the output register
// depends on brs_pkg
module brs_out (
  input  logic                       clk,
  input  logic                       rst,
  input  brs_pkg::emit_req_t         req,
  input  logic [brs_pkg::RANK_W-1:0] peer_val,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 action,
  output logic [brs_pkg::RANK_W-1:0] peer,
  output logic                       last
);
  import brs_pkg::*;

  logic              pvalid;
  logic [2:0]        pact;
  logic [RANK_W-1:0] ppeer;
  logic [NUM_W-1:0]  num;
  logic              take;
  logic              push;

  assign busy = pvalid && out_valid && !out_ready;
  assign take = req.emit && (num < NUM_W'(OUT_LIMIT));
  assign push = (take || req.flush) && pvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
      out_valid <= 1'b0;
      num <= '0;
    end else begin
      if (req.start) begin
        num <= '0;
      end else if (take) begin
        num <= num + NUM_W'(1);
      end
      if (take) begin
        pvalid <= 1'b1;
      end else if (req.flush) begin
        pvalid <= 1'b0;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pact <= req.act;
      ppeer <= peer_val;
    end
    if (push) begin
      action <= pact;
      peer <= ppeer;
      last <= req.flush;
    end
  end

endmodule

// File: sim/binomial_reduce_schedule_test.sv
`timescale 1ns / 1ps
// testbench for binomial_reduce_schedule: directed and random reduce requests,
// each checked action by action against a predicted binomial-tree action list
// depends on brs_pkg and the binomial_reduce_schedule rtl
module binomial_reduce_schedule_test;
  import brs_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [30:0] COUNT_MAX = 31'h7fffffff;

  typedef struct packed {
    logic [RANK_W-1:0]  root;
    logic               comm;
    logic               inpl;
    logic [COUNT_W-1:0] count;
  } request_t;

  typedef struct packed {
    logic [2:0]        act;
    logic [RANK_W-1:0] peer;
    logic              last;
  } step_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_GROUP_SIZE;
  logic [GROUP_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [RANK_W-1:0] root_rank = '0;
  logic commutative = 1'b0;
  logic in_place = 1'b0;
  logic [COUNT_W-1:0] element_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] action;
  logic [RANK_W-1:0] peer;
  logic last;

  binomial_reduce_schedule i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .root_rank(root_rank),
    .commutative(commutative),
    .in_place(in_place),
    .element_count(element_count),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .action(action),
    .peer(peer),
    .last(last)
  );

  // register copies used for prediction
  logic [GROUP_W-1:0] group_size_now = 11'd1;
  logic [RANK_W-1:0]  rank_now = '0;

  request_t pending_requests[$];
  step_t    expected_steps[$];
  step_t    plan_buf[OUT_LIMIT];
  int       plan_len;

  int outstanding = 0;
  int requests_taken = 0;
  int steps_checked = 0;
  int settings_used = 0;
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d actions still expected", cycles,
               expected_steps.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned effective_group(logic [GROUP_W-1:0] g);
    if (g == 0) return 1;
    if (g > MAX_RANKS_DEF) return MAX_RANKS_DEF;
    return {21'b0, g};
  endfunction

  function automatic void add_step(logic [2:0] act, int unsigned partner);
    if (plan_len < OUT_LIMIT) begin
      plan_buf[plan_len].act = act;
      plan_buf[plan_len].peer = partner[RANK_W-1:0];
      plan_buf[plan_len].last = 1'b0;
      plan_len++;
    end
  endfunction

  // builds this node's action list and queues it as expected output
  function automatic void plan_reduce(request_t req);
    int unsigned g;
    int unsigned lroot;
    int unsigned rel;
    int unsigned mask;
    int unsigned child;
    plan_len = 0;
    if (req.count == 0) return;
    g = effective_group(group_size_now);
    if (32'(req.root) >= g || 32'(rank_now) >= g) begin
      add_step(ACT_ERROR, 0);
    end else begin
      if (rank_now != req.root || !req.inpl) add_step(ACT_COPY_IN, 0);
      lroot = req.comm ? 32'(req.root) : 0;
      rel = (32'(rank_now) + g - lroot) % g;
      mask = 1;
      while (mask < g) begin
        if ((rel & mask) == 0) begin
          child = rel | mask;
          if (child < g) begin
            add_step(ACT_RECV_TMP, (child + lroot) % g);
            if (req.comm) begin
              add_step(ACT_RED_TMP_LOCAL, 0);
            end else begin
              add_step(ACT_RED_LOCAL_TMP, 0);
              add_step(ACT_COPY_BACK, 0);
            end
          end
          mask = mask << 1;
        end else begin
          add_step(ACT_SEND, ((rel & ~mask) + lroot) % g);
          mask = g;
        end
      end
      // final hop from rank 0 to the real root
      if (!req.comm && req.root != 0) begin
        if (rank_now == 0) add_step(ACT_SEND, 32'(req.root));
        else if (rank_now == req.root) add_step(ACT_RECV_LOCAL, 0);
      end
    end
    for (int i = 0; i < plan_len; i++) begin
      plan_buf[i].last = (i == plan_len - 1);
      expected_steps.push_back(plan_buf[i]);
    end
  endfunction

  // request driver
  always @(posedge clk) begin : request_driver
    request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        plan_reduce('{root: root_rank, comm: commutative, inpl: in_place,
                      count: element_count});
        requests_taken++;
        outstanding--;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (pending_requests.size() > 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        in_valid <= 1'b1;
        root_rank <= nxt.root;
        commutative <= nxt.comm;
        in_place <= nxt.inpl;
        element_count <= nxt.count;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // action monitor
  always @(posedge clk) begin : action_monitor
    step_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        steps_checked++;
        if (expected_steps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected action %0d peer %0d last %0b", action, peer, last);
        end else begin
          want = expected_steps.pop_front();
          if (action !== want.act || peer !== want.peer || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected act %0d peer %0d last %0b, got %0d %0d %0b",
                       want.act, want.peer, want.last, action, peer, last);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [GROUP_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_GROUP_SIZE) group_size_now = val;
    else rank_now = val[RANK_W-1:0];
  endtask

  task automatic set_group(logic [GROUP_W-1:0] g, logic [RANK_W-1:0] r);
    write_reg(REG_GROUP_SIZE, g);
    write_reg(REG_MY_RANK, {1'b0, r});
    settings_used++;
  endtask

  task automatic queue_request(logic [RANK_W-1:0] root, logic comm, logic inpl,
                               logic [COUNT_W-1:0] count);
    pending_requests.push_back('{root: root, comm: comm, inpl: inpl, count: count});
    outstanding++;
  endtask

  // sender holds off until every queued request is answered
  task automatic wait_schedule_drained();
    @(posedge clk);
    while (outstanding != 0 || expected_steps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic random_request();
    int unsigned g;
    logic [RANK_W-1:0] root;
    logic [COUNT_W-1:0] count;
    g = effective_group(group_size_now);
    if ($urandom_range(0, 99) < 85) root = RANK_W'($urandom_range(0, g - 1));
    else root = RANK_W'($urandom_range(0, 1023));
    case ($urandom_range(0, 19))
      0, 1: count = '0;
      2: count = COUNT_MAX;
      3: count = 31'd1;
      default: count = COUNT_W'($urandom);
    endcase
    queue_request(root, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), count);
  endtask

  task automatic random_setting();
    logic [GROUP_W-1:0] g;
    logic [RANK_W-1:0] r;
    int unsigned ge;
    case ($urandom_range(0, 9))
      0: g = 11'd1;
      1: g = 11'd2;
      2: g = 11'd1024;
      3: g = GROUP_W'($urandom_range(1025, 2047));
      4: g = 11'd0;
      default: g = GROUP_W'($urandom_range(2, 1024));
    endcase
    ge = effective_group(g);
    if ($urandom_range(0, 99) < 85) r = RANK_W'($urandom_range(0, ge - 1));
    else r = RANK_W'($urandom_range(0, 1023));
    set_group(g, r);
  endtask

  initial begin : stimulus
    send_idle_pct = 30;
    recv_idle_pct = 79;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset setting: one rank, in-place root gives an empty list
    queue_request(10'd0, 1'b1, 1'b1, 31'd1);
    queue_request(10'd0, 1'b0, 1'b0, COUNT_MAX);
    queue_request(10'd1, 1'b1, 1'b0, 31'd5);
    wait_schedule_drained();

    set_group(11'd8, 10'd0);
    queue_request(10'd0, 1'b1, 1'b0, 31'd1);
    queue_request(10'd0, 1'b0, 1'b1, 31'd1);
    queue_request(10'd5, 1'b0, 1'b0, 31'd7);
    queue_request(10'd5, 1'b1, 1'b0, 31'd3);
    queue_request(10'd0, 1'b1, 1'b1, 31'd0);
    queue_request(10'd1023, 1'b1, 1'b0, 31'd1);
    queue_request(10'd7, 1'b0, 1'b1, COUNT_MAX);
    wait_schedule_drained();

    set_group(11'd8, 10'd5);
    queue_request(10'd5, 1'b0, 1'b1, 31'd1);
    queue_request(10'd5, 1'b1, 1'b1, 31'd1);
    queue_request(10'd3, 1'b0, 1'b0, 31'd2);
    queue_request(10'd2, 1'b1, 1'b0, 31'h40000000);
    wait_schedule_drained();

    // group size above the limit saturates
    set_group(11'd2047, 10'd1023);
    queue_request(10'd0, 1'b1, 1'b0, 31'd1);
    queue_request(10'd1023, 1'b0, 1'b1, 31'd1);
    queue_request(10'd512, 1'b0, 1'b0, 31'd9);
    wait_schedule_drained();

    set_group(11'd1024, 10'd0);
    queue_request(10'd0, 1'b0, 1'b0, 31'd1);
    queue_request(10'd1023, 1'b0, 1'b0, 31'd1);
    queue_request(10'd0, 1'b1, 1'b1, 31'd1);
    wait_schedule_drained();

    // group size zero acts as one rank
    set_group(11'd0, 10'd0);
    queue_request(10'd0, 1'b1, 1'b1, 31'd1);
    queue_request(10'd0, 1'b0, 1'b0, 31'd1);
    wait_schedule_drained();

    // own rank outside the group
    set_group(11'd5, 10'd7);
    queue_request(10'd0, 1'b1, 1'b0, 31'd1);
    queue_request(10'd0, 1'b1, 1'b0, 31'd0);
    wait_schedule_drained();

    for (int p = 0; p < 10; p++) begin
      if (p < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 79;
      end else if (p < 7) begin
        send_idle_pct = 79;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_setting();
      repeat (6) random_request();
      wait_schedule_drained();
      repeat (6) random_request();
      wait_schedule_drained();
    end

    repeat (30) @(posedge clk);
    if (expected_steps.size() != 0) mismatches++;
    $display("checked %0d actions from %0d reduce requests", steps_checked,
             requests_taken);
    $display("over %0d group settings, %0d mismatches", settings_used, mismatches);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
